FILE: rtl/phsd_pkg.sv
// Package for the pixel hit stream decoder.
// Holds the shared codes, constants and the queue entry type; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package phsd_pkg;

    localparam logic [7:0]  HDR_MARKER    = 8'h5a;
    localparam logic [7:0]  TRAILER_BYTE  = 8'ha5;
    localparam logic [24:0] HDR_BYTES     = 25'd12;
    localparam logic [25:0] MIN_PACKET    = 26'd16;
    localparam logic [24:0] SIZE_OVERHEAD = 25'd16;
    localparam logic [24:0] COUNT_MAX     = 25'h1ffffff;
    localparam logic [4:0]  REGION_RESET  = 5'd31;

    // Header byte positions.
    localparam logic [24:0] IDX_MARKER  = 25'd0;
    localparam logic [24:0] IDX_DEVICE  = 25'd3;
    localparam logic [24:0] IDX_LEN0    = 25'd4;
    localparam logic [24:0] IDX_LEN1    = 25'd5;
    localparam logic [24:0] IDX_LEN2    = 25'd6;
    localparam logic [24:0] IDX_TRIG_LO = 25'd8;
    localparam logic [24:0] IDX_TRIG_HI = 25'd9;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_SHORT         = 3'd1,
        ST_BAD_HEADER    = 3'd2,
        ST_SIZE_MISMATCH = 3'd3,
        ST_BAD_TRAILER   = 3'd4,
        ST_TRUNCATED     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_word_phase;

    typedef enum logic [1:0] {
        WT_SKIP  = 2'd0,
        WT_SHORT = 2'd1,
        WT_LONG  = 2'd2
    } t_word_type;

    // One queue entry: either a group of hits from one data word or a packet status.
    typedef struct packed {
        logic        is_status;
        t_status     status;
        logic [7:0]  dev;
        logic [15:0] trig;
        logic [4:0]  region;
        logic [3:0]  encoder;
        logic [9:0]  address;
        logic [7:0]  hit_mask;   // bit 0 is the base hit, bit i the neighbour at addr+i
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

FILE: rtl/pixel_hit_stream_decoder_top.sv
// Top level of the pixel hit stream decoder.
// Connects phsd_front, phsd_queue and phsd_back; uses phsd_pkg.
//
//  Channel | Dir | tdata (low bit up)                       | tuser | tlast
//  s       | in  | data_byte[7:0]                           | -     | last
//  m       | out | col_x, row_y, device_id, trigger_id,     | kind  | end_of_run
//          |     | status, one zero pad bit (48 bits)       |       |
//
// The front end takes one byte per cycle whenever the queue has a free entry, also
// while a result waits at the output. Each queue entry holds all results of one byte
// (up to eight hits of a long data word, or one packet status); the back end turns
// it into results at one per cycle unless the output stalls, so a long data word
// holds the queue head until its last hit is taken. Results leave through a
// registered output stage. Reset is synchronous and active low; it empties the
// queue and puts the packet state back to its start-of-packet values.
`timescale 1ns / 1ps
`default_nettype none

module pixel_hit_stream_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Input bytes.
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [7:0]   i_s_tdata,   // [7:0] data_byte
    input  wire          i_s_tlast,
    // Results.
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [47:0]  o_m_tdata,   // [9:0] col_x, [19:10] row_y, [27:20] device_id,
                                      // [43:28] trigger_id, [46:44] status, [47] zero
    output logic         o_m_tuser,   // [0] kind
    output logic         o_m_tlast
);
    import phsd_pkg::*;

    logic         w_fq_valid;
    logic         w_fq_ready;
    t_entry       w_fq_entry;
    logic         w_qb_valid;
    logic         w_qb_ready;
    t_entry       w_qb_entry;

    logic [9:0]   w_col_x;
    logic [9:0]   w_row_y;
    logic [7:0]   w_device_id;
    logic [15:0]  w_trigger_id;
    logic [2:0]   w_status;

    // The front end only advances its packet state on a beat that the queue can take.
    phsd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_byte    (i_s_tdata),
        .i_last    (i_s_tlast),
        .i_q_ready (w_fq_ready),
        .o_q_valid (w_fq_valid),
        .o_q_entry (w_fq_entry)
    );

    assign o_s_tready = w_fq_ready;

    phsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .o_ready (w_fq_ready),
        .i_entry (w_fq_entry),
        .o_valid (w_qb_valid),
        .i_ready (w_qb_ready),
        .o_entry (w_qb_entry)
    );

    phsd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_qb_valid),
        .i_q_entry    (w_qb_entry),
        .o_q_ready    (w_qb_ready),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_kind       (o_m_tuser),
        .o_col_x      (w_col_x),
        .o_row_y      (w_row_y),
        .o_device_id  (w_device_id),
        .o_trigger_id (w_trigger_id),
        .o_status     (w_status),
        .o_end_of_run (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, w_status, w_trigger_id, w_device_id, w_row_y, w_col_x};

endmodule

`default_nettype wire

FILE: rtl/phsd_front.sv
// Front end of the pixel hit stream decoder: header checks and payload word decoding.
// Produces one queue entry per byte that causes results; uses phsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module phsd_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire [7:0]           i_byte,
    input  wire                 i_last,
    input  wire                 i_q_ready,
    output logic                o_q_valid,
    output phsd_pkg::t_entry    o_q_entry
);
    import phsd_pkg::*;

    logic [24:0]  r_byte_count, n_byte_count;
    logic [23:0]  r_payload_len, n_payload_len;
    logic [7:0]   r_dev, n_dev;
    logic [15:0]  r_trig, n_trig;
    logic [4:0]   r_region, n_region;
    t_word_phase  r_phase, n_phase;
    t_word_type   r_wtype, n_wtype;
    logic [3:0]   r_encoder, n_encoder;
    logic [9:0]   r_address, n_address;
    t_status      r_error, n_error;

    logic         w_accept;
    logic [24:0]  w_trailer_idx;
    logic [25:0]  w_total;
    logic [24:0]  w_expect;
    logic         w_in_payload;
    logic         w_at_trailer;
    logic         w_emit;
    t_entry       w_entry;

    assign w_accept = i_valid && i_q_ready;

    always_comb begin
        n_byte_count  = r_byte_count;
        n_payload_len = r_payload_len;
        n_dev         = r_dev;
        n_trig        = r_trig;
        n_region      = r_region;
        n_phase       = r_phase;
        n_wtype       = r_wtype;
        n_encoder     = r_encoder;
        n_address     = r_address;
        n_error       = r_error;
        w_emit        = 1'b0;
        w_entry       = '0;

        // Header fields.
        if (r_byte_count == IDX_MARKER && i_byte != HDR_MARKER) begin
            n_error = ST_BAD_HEADER;
        end
        if (r_byte_count == IDX_DEVICE) begin
            n_dev = i_byte;
        end
        if (r_byte_count == IDX_LEN0) begin
            n_payload_len[7:0] = r_payload_len[7:0] | i_byte;
        end
        if (r_byte_count == IDX_LEN1) begin
            n_payload_len[15:8] = r_payload_len[15:8] | i_byte;
        end
        if (r_byte_count == IDX_LEN2) begin
            n_payload_len[23:16] = r_payload_len[23:16] | i_byte;
        end
        if (r_byte_count == IDX_TRIG_LO) begin
            n_trig[7:0] = i_byte;
        end
        if (r_byte_count == IDX_TRIG_HI) begin
            n_trig[15:8] = i_byte;
        end

        w_trailer_idx = HDR_BYTES + {1'b0, n_payload_len};
        w_in_payload  = (r_byte_count >= HDR_BYTES) && (r_byte_count < w_trailer_idx);
        w_at_trailer  = (r_byte_count >= HDR_BYTES) && (r_byte_count == w_trailer_idx);

        w_entry.dev   = n_dev;
        w_entry.trig  = n_trig;

        if (w_in_payload) begin
            if (!i_last) begin
                case (r_phase)
                    PH_FIRST: begin
                        if (i_byte[7]) begin
                            if (i_byte[7:4] inside {4'he, 4'ha}) begin
                                n_wtype = WT_SKIP;
                                n_phase = PH_SECOND;
                            end else if (i_byte[7:5] == 3'b110) begin
                                n_region = i_byte[4:0];
                            end
                        end else begin
                            n_encoder = i_byte[5:2];
                            n_address = {i_byte[1:0], 8'h00};
                            n_wtype   = i_byte[6] ? WT_SHORT : WT_LONG;
                            n_phase   = PH_SECOND;
                        end
                    end
                    PH_SECOND: begin
                        if (r_wtype == WT_SKIP) begin
                            n_phase = PH_FIRST;
                        end else begin
                            n_address = {r_address[9:8], i_byte};
                            if (r_wtype == WT_SHORT) begin
                                w_emit           = 1'b1;
                                w_entry.hit_mask = 8'h01;
                                n_phase          = PH_FIRST;
                            end else begin
                                n_phase = PH_THIRD;
                            end
                        end
                    end
                    PH_THIRD: begin
                        w_emit           = 1'b1;
                        w_entry.hit_mask = {i_byte[6:0], 1'b1};
                        n_phase          = PH_FIRST;
                    end
                    default: begin
                        n_phase = PH_FIRST;
                    end
                endcase
            end
        end else if (w_at_trailer) begin
            if (r_error == ST_OK) begin
                if (i_byte != TRAILER_BYTE) begin
                    n_error = ST_BAD_TRAILER;
                end else if (r_phase != PH_FIRST) begin
                    n_error = ST_TRUNCATED;
                end
            end
            n_phase = PH_FIRST;
        end

        w_entry.region  = n_region;
        w_entry.encoder = n_encoder;
        w_entry.address = n_address;

        if (r_byte_count != COUNT_MAX) begin
            n_byte_count = r_byte_count + 25'd1;
        end

        // Packet end: one status, then every register returns to its reset value.
        w_total  = {1'b0, r_byte_count} + 26'd1;
        w_expect = ({1'b0, n_payload_len} + SIZE_OVERHEAD) & ~25'd3;
        if (i_last) begin
            w_emit            = 1'b1;
            w_entry.is_status = 1'b1;
            w_entry.hit_mask  = '0;
            w_entry.region    = '0;
            w_entry.encoder   = '0;
            w_entry.address   = '0;
            if (w_total < MIN_PACKET) begin
                w_entry.status = ST_SHORT;
            end else if (n_error == ST_BAD_HEADER) begin
                w_entry.status = ST_BAD_HEADER;
            end else if (w_total != {1'b0, w_expect}) begin
                w_entry.status = ST_SIZE_MISMATCH;
            end else begin
                w_entry.status = n_error;
            end
            n_byte_count  = '0;
            n_payload_len = '0;
            n_dev         = '0;
            n_trig        = '0;
            n_region      = REGION_RESET;
            n_phase       = PH_FIRST;
            n_wtype       = WT_SKIP;
            n_encoder     = '0;
            n_address     = '0;
            n_error       = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_payload_len <= '0;
            r_dev         <= '0;
            r_trig        <= '0;
            r_region      <= REGION_RESET;
            r_phase       <= PH_FIRST;
            r_wtype       <= WT_SKIP;
            r_encoder     <= '0;
            r_address     <= '0;
            r_error       <= ST_OK;
        end else if (w_accept) begin
            r_byte_count  <= n_byte_count;
            r_payload_len <= n_payload_len;
            r_dev         <= n_dev;
            r_trig        <= n_trig;
            r_region      <= n_region;
            r_phase       <= n_phase;
            r_wtype       <= n_wtype;
            r_encoder     <= n_encoder;
            r_address     <= n_address;
            r_error       <= n_error;
        end
    end

    assign o_q_valid = i_valid && w_emit;
    assign o_q_entry = w_entry;

endmodule

`default_nettype wire

FILE: rtl/phsd_queue.sv
// Short register queue between the decoder front end and the hit expander.
// Holds phsd_pkg::t_entry items; uses phsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module phsd_queue #(
    parameter int DEPTH = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  phsd_pkg::t_entry    i_entry,
    output logic                o_valid,
    input  wire                 i_ready,
    output phsd_pkg::t_entry    o_entry
);
    import phsd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               w_push, w_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/phsd_back.sv
// Back end of the pixel hit stream decoder: expands queue entries into results,
// one per cycle unless stalled, into a registered output stage; uses phsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module phsd_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  phsd_pkg::t_entry    i_q_entry,
    output logic                o_q_ready,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic                o_kind,
    output logic [9:0]          o_col_x,
    output logic [9:0]          o_row_y,
    output logic [7:0]          o_device_id,
    output logic [15:0]         o_trigger_id,
    output logic [2:0]          o_status,
    output logic                o_end_of_run
);
    import phsd_pkg::*;

    logic [7:0]   r_done, n_done;
    logic         r_valid;
    logic         r_kind;
    logic [9:0]   r_col, r_row;
    logic [7:0]   r_dev;
    logic [15:0]  r_trig;
    logic [2:0]   r_status;
    logic         r_last;

    logic         w_out_free;
    logic         w_take;
    logic [7:0]   w_rem;
    logic [2:0]   w_sel;
    logic [7:0]   w_sel_hot;
    logic         w_group_end;
    logic [10:0]  w_addr;

    assign w_out_free = !r_valid || i_ready;
    assign w_take     = w_out_free && i_q_valid;
    assign w_rem      = i_q_entry.hit_mask & ~r_done;

    // Lowest hit still pending in the head entry.
    always_comb begin
        w_sel = '0;
        for (int k = 7; k >= 0; k--) begin
            if (w_rem[k]) begin
                w_sel = 3'(k);
            end
        end
    end

    assign w_sel_hot   = 8'h01 << w_sel;
    assign w_group_end = i_q_entry.is_status || ((w_rem & ~w_sel_hot) == '0);
    assign w_addr      = {1'b0, i_q_entry.address} + {8'h00, w_sel};
    assign o_q_ready   = w_out_free && w_group_end;

    always_comb begin
        n_done = r_done;
        if (w_take) begin
            n_done = w_group_end ? '0 : (r_done | w_sel_hot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_done <= n_done;
            if (w_out_free) begin
                r_valid <= i_q_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_kind  <= i_q_entry.is_status;
            r_dev   <= i_q_entry.dev;
            r_trig  <= i_q_entry.trig;
            r_last  <= w_group_end;
            if (i_q_entry.is_status) begin
                r_col    <= '0;
                r_row    <= '0;
                r_status <= i_q_entry.status;
            end else begin
                r_col    <= {i_q_entry.region, i_q_entry.encoder, w_addr[0] ^ w_addr[1]};
                r_row    <= w_addr[10:1];
                r_status <= ST_OK;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_col_x      = r_col;
    assign o_row_y      = r_row;
    assign o_device_id  = r_dev;
    assign o_trigger_id = r_trig;
    assign o_status     = r_status;
    assign o_end_of_run = r_last;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for pixel_hit_stream_decoder_top.
// Holds a scoreboard class with its own decoder model, the stream drivers and the
// packet generator; depends on phsd_pkg and the RTL top level only.
`timescale 1ns / 1ps

module testbench;

    import phsd_pkg::*;

    // Run shape. The watchdog limit covers the long receiver hold-off with a wide
    // margin.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_BYTES     = 40;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HDR_LEN         = 12;

    // One result beat as the block should present it.
    typedef struct packed {
        logic        kind;
        logic [9:0]  col_x;
        logic [9:0]  row_y;
        logic [7:0]  device_id;
        logic [15:0] trigger_id;
        logic [2:0]  status;
        logic        end_of_run;
    } t_decoded_result;

    // Kinds of generated packets and of payload words.
    typedef enum int {
        PK_GOOD, PK_BAD_MARKER, PK_BAD_TRAILER, PK_TRUNCATED,
        PK_WRONG_SIZE, PK_SHORT, PK_CUT_PAYLOAD, PK_NOISE
    } t_packet_kind;

    typedef enum int {
        WK_BUSY, WK_EMPTY, WK_REGION, WK_CHIP_TRAILER,
        WK_CHIP_HEADER, WK_UNDEFINED, WK_SHORT, WK_LONG
    } t_word_kind;

    // The scoreboard keeps its own copy of the packet state. note_byte runs on every
    // accepted input beat and queues the hits and the status that the byte causes;
    // check_result pops the oldest of them for every accepted output beat.
    class decoder_scoreboard;
        bit [24:0]        byte_idx;
        bit [23:0]        pay_len;
        bit [7:0]         dev_id;
        bit [15:0]        trig_id;
        bit [4:0]         region;
        t_word_phase      phase;
        t_word_type       wtype;
        bit [3:0]         encoder;
        bit [9:0]         address;
        t_status          err;
        t_decoded_result  due_results[$];
        int               errors;

        function new();
            errors = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            byte_idx = '0;
            pay_len  = '0;
            dev_id   = '0;
            trig_id  = '0;
            region   = REGION_RESET;
            phase    = PH_FIRST;
            wtype    = WT_SKIP;
            encoder  = '0;
            address  = '0;
            err      = ST_OK;
        endfunction

        function void add_hit(bit [10:0] addr);
            t_decoded_result r;
            r.kind       = 1'b0;
            r.col_x      = {region, 5'd0} + {5'd0, encoder, 1'b0} + (addr[0] ^ addr[1]);
            r.row_y      = addr[10:1];
            r.device_id  = dev_id;
            r.trigger_id = trig_id;
            r.status     = ST_OK;
            r.end_of_run = 1'b0;
            due_results.push_back(r);
        endfunction

        // One payload byte through the word decoder.
        function void decode_payload_byte(bit [7:0] b);
            bit [10:0] base;
            int i;
            case (phase)
                PH_FIRST: begin
                    if (b[7]) begin
                        if (b[7:4] == 4'hE || b[7:4] == 4'hA) begin
                            wtype = WT_SKIP;
                            phase = PH_SECOND;
                        end else if (b[7:5] == 3'b110) begin
                            region = b[4:0];
                        end
                    end else begin
                        encoder = b[5:2];
                        address = {b[1:0], 8'd0};
                        wtype   = b[6] ? WT_SHORT : WT_LONG;
                        phase   = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    if (wtype == WT_SKIP) begin
                        phase = PH_FIRST;
                    end else begin
                        address[7:0] = b;
                        if (wtype == WT_SHORT) begin
                            add_hit({1'b0, address});
                            phase = PH_FIRST;
                        end else begin
                            phase = PH_THIRD;
                        end
                    end
                end
                default: begin
                    // Hit map: bit i-1 adds the neighbour at address + i.
                    base = {1'b0, address};
                    add_hit(base);
                    for (i = 1; i <= 7; i++)
                        if (b[i-1]) add_hit(base + i[10:0]);
                    phase = PH_FIRST;
                end
            endcase
        endfunction

        function void note_byte(bit [7:0] b, bit l);
            bit [24:0]       idx;
            bit [24:0]       trailer_pos;
            bit [25:0]       total;
            bit [25:0]       want;
            t_status         st;
            int              prior_size;
            t_decoded_result r;
            prior_size = due_results.size();
            idx        = byte_idx;
            if (idx == IDX_MARKER && b != HDR_MARKER) err = ST_BAD_HEADER;
            if (idx == IDX_DEVICE)  dev_id        = b;
            if (idx == IDX_LEN0)    pay_len[7:0]  = b;
            if (idx == IDX_LEN1)    pay_len[15:8] = b;
            if (idx == IDX_LEN2)    pay_len[23:16] = b;
            if (idx == IDX_TRIG_LO) trig_id[7:0]  = b;
            if (idx == IDX_TRIG_HI) trig_id[15:8] = b;

            trailer_pos = HDR_BYTES + {1'b0, pay_len};
            if (idx >= HDR_BYTES && idx < trailer_pos) begin
                if (!l) decode_payload_byte(b);
            end else if (idx >= HDR_BYTES && idx == trailer_pos) begin
                if (err == ST_OK) begin
                    if (b != TRAILER_BYTE) err = ST_BAD_TRAILER;
                    else if (phase != PH_FIRST) err = ST_TRUNCATED;
                end
                phase = PH_FIRST;
            end
            if (byte_idx != COUNT_MAX) byte_idx++;

            if (l) begin
                total = {1'b0, idx} + 26'd1;
                want  = ({2'b00, pay_len} + {1'b0, SIZE_OVERHEAD}) & ~26'd3;
                if (total < MIN_PACKET)       st = ST_SHORT;
                else if (err == ST_BAD_HEADER) st = ST_BAD_HEADER;
                else if (total != want)        st = ST_SIZE_MISMATCH;
                else                           st = err;
                r = '0;
                r.kind       = 1'b1;
                r.device_id  = dev_id;
                r.trigger_id = trig_id;
                r.status     = st;
                due_results.push_back(r);
                clear_packet();
            end

            if (due_results.size() > prior_size) begin
                r = due_results.pop_back();
                r.end_of_run = 1'b1;
                due_results.push_back(r);
            end
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [47:0] tdata, logic tuser, logic tlast);
            t_decoded_result r;
            if (due_results.size() == 0) begin
                $error("result beat with nothing expected: tdata %h", tdata);
                errors++;
                return;
            end
            r = due_results.pop_front();
            check_field("kind",       r.kind,       tuser);
            check_field("col_x",      r.col_x,      tdata[9:0]);
            check_field("row_y",      r.row_y,      tdata[19:10]);
            check_field("device_id",  r.device_id,  tdata[27:20]);
            check_field("trigger_id", r.trigger_id, tdata[43:28]);
            check_field("status",     r.status,     tdata[46:44]);
            check_field("pad",        1'b0,         tdata[47]);
            check_field("end_of_run", r.end_of_run, tlast);
        endfunction
    endclass

    // All inputs of the block hold known values from time zero.
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [47:0] m_tdata;
    wire         m_tuser;
    wire         m_tlast;

    // Idling controls, changed by the stimulus between phases. hold_left makes the
    // receiver hold off while it is above zero; it is counted down by the receiver.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    decoder_scoreboard sb;
    logic [7:0] pkt[$];

    pixel_hit_stream_decoder_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: random stalls at the phase rate, or a solid hold-off when asked.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Output monitor. Handshake signals are sampled at the edge before any
    // nonblocking update lands, so the check sees exactly what the block saw.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // Watchdog: ends the run when neither side has moved a beat for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Offers one byte and returns right after the edge that accepted it. tvalid is
    // only lowered when an idle gap is taken, so a back-to-back beat never sees a
    // low and a high assignment in the same time step.
    task automatic push_beat(input logic [7:0] b, input logic l);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do @(posedge clk); while (!s_tready);
        sb.note_byte(b, l);
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt.size(); i++)
            push_beat(pkt[i], i == pkt.size() - 1);
    endtask

    // Stops offering and waits until every expected result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.due_results.size() != 0);
    endtask

    // Appends one payload word. With open set, only the leading bytes of a
    // multi-byte word go in, so the word is still open at the trailer.
    task automatic add_word(input logic open);
        t_word_kind open_kinds[4];
        t_word_kind wk;
        int         roll;
        logic [7:0] r;
        logic [7:0] s;
        logic [7:0] t;
        open_kinds = '{WK_EMPTY, WK_CHIP_HEADER, WK_SHORT, WK_LONG};
        r = $urandom;
        s = $urandom;
        t = $urandom;
        roll = $urandom_range(0, 11);
        // Data words are drawn more often than the rest.
        if (open)           wk = open_kinds[$urandom_range(0, 3)];
        else if (roll <= 7) wk = t_word_kind'(roll);
        else                wk = roll[0] ? WK_SHORT : WK_LONG;
        case (wk)
            WK_BUSY:         pkt.push_back({4'hF, r[3:0]});
            WK_EMPTY: begin
                pkt.push_back({4'hE, r[3:0]});
                if (!open) pkt.push_back(s);
            end
            WK_REGION:       pkt.push_back({3'b110, r[4:0]});
            WK_CHIP_TRAILER: pkt.push_back({4'hB, r[3:0]});
            WK_CHIP_HEADER: begin
                pkt.push_back({4'hA, r[3:0]});
                if (!open) pkt.push_back(s);
            end
            WK_UNDEFINED:    pkt.push_back({3'b100, r[4:0]});
            WK_SHORT: begin
                pkt.push_back({2'b01, r[5:0]});
                if (!open) pkt.push_back(s);
            end
            default: begin
                pkt.push_back({2'b00, r[5:0]});
                if (!open || r[7]) pkt.push_back(s);
                if (!open) pkt.push_back(t);
            end
        endcase
    endtask

    // Builds one random packet. Most are well formed with random content so that
    // the decoder gets deep into payloads; the rest carry one defect each.
    task automatic build_packet();
        t_packet_kind kind;
        int           roll;
        int           nbytes;
        int           len;
        int           want;
        int           i;
        logic [7:0]   r;
        roll = $urandom_range(0, 99);
        if (roll < 58)      kind = PK_GOOD;
        else if (roll < 65) kind = PK_BAD_MARKER;
        else if (roll < 72) kind = PK_BAD_TRAILER;
        else if (roll < 80) kind = PK_TRUNCATED;
        else if (roll < 87) kind = PK_WRONG_SIZE;
        else if (roll < 92) kind = PK_SHORT;
        else if (roll < 97) kind = PK_CUT_PAYLOAD;
        else                kind = PK_NOISE;
        pkt.delete();

        if (kind == PK_NOISE || kind == PK_SHORT) begin
            nbytes = (kind == PK_NOISE) ? $urandom_range(1, 30) : $urandom_range(1, 15);
            for (i = 0; i < nbytes; i++) begin
                r = $urandom;
                pkt.push_back(r);
            end
            if (kind == PK_SHORT) pkt[0] = HDR_MARKER;
            return;
        end

        // Header; the length bytes are filled in once the payload is known.
        r = $urandom;
        if (r == HDR_MARKER) r = ~r;
        pkt.push_back(kind == PK_BAD_MARKER ? r : HDR_MARKER);
        for (i = 1; i < HDR_LEN; i++) begin
            r = $urandom;
            pkt.push_back(r);
        end
        repeat ($urandom_range(0, 5)) add_word(1'b0);
        if (kind == PK_TRUNCATED) add_word(1'b1);
        len = pkt.size() - HDR_LEN;
        pkt[4] = len[7:0];
        pkt[5] = len[15:8];
        pkt[6] = len[23:16];

        r = $urandom;
        if (r == TRAILER_BYTE) r = ~r;
        pkt.push_back(kind == PK_BAD_TRAILER ? r : TRAILER_BYTE);
        want = (len + 16) & ~3;
        while (pkt.size() < want) begin
            r = $urandom;
            pkt.push_back(r);
        end

        if (kind == PK_WRONG_SIZE) begin
            if ($urandom_range(0, 1)) begin
                repeat ($urandom_range(1, 5)) begin
                    r = $urandom;
                    pkt.push_back(r);
                end
            end else begin
                repeat ($urandom_range(1, 3)) pkt.delete(pkt.size() - 1);
            end
        end

        if (kind == PK_CUT_PAYLOAD) begin
            if (len == 0 || $urandom_range(0, 1)) begin
                // A huge length field: trailer and padding are decoded as payload and
                // the last byte always lands inside it.
                r = $urandom;
                pkt[6] = r | 8'h01;
            end else begin
                nbytes = HDR_LEN + $urandom_range(1, len);
                while (pkt.size() > nbytes) pkt.delete(pkt.size() - 1);
            end
        end
    endtask

    // Directed packets: every word type, region reset value, largest hit map at the
    // top address, padding past the trailer, then a short packet with a bad marker.
    task automatic send_directed();
        logic [7:0] full_pkt [0:27];
        logic [7:0] short_pkt [0:2];
        int i;
        full_pkt = '{8'h5a, 8'h01, 8'h02, 8'h3c, 8'h0d, 8'h00, 8'h00, 8'hff,
                     8'h34, 8'h12, 8'h00, 8'h00,
                     8'h43, 8'h00,          // short data before any region header
                     8'hf3,                 // busy
                     8'he1, 8'h77,          // empty frame
                     8'hc5,                 // region header
                     8'ha2, 8'h12,          // chip header
                     8'hb4,                 // chip trailer
                     8'h9f,                 // undefined
                     8'h3f, 8'hff, 8'h7f,   // long data, top address, full hit map
                     8'ha5, 8'hee, 8'h11};
        short_pkt = '{8'hc3, 8'h5a, 8'hff};
        pkt.delete();
        for (i = 0; i < 28; i++) pkt.push_back(full_pkt[i]);
        send_packet();
        pkt.delete();
        for (i = 0; i < 3; i++) pkt.push_back(short_pkt[i]);
        send_packet();
    endtask

    initial begin
        int ph;
        int phase_sent;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();

        // Random phases: no idling, sender idle, receiver stalling, then both.
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 55; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 55; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            // A long hold-off while bytes keep coming, so the queue fills and the
            // block has to stall its input.
            if (ph == 2) hold_left = HOLD_OFF_CYCLES;
            phase_sent = 0;
            while (phase_sent < PHASE_BYTES) begin
                build_packet();
                send_packet();
                phase_sent += pkt.size();
            end
            // Once in the run, the sender pauses until everything has come out.
            if (ph == 0) drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
